>>> sv/assert_macros.svh
// Assertion macros shared by the billboard quad expander RTL.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the cycle after ante
`define BQE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// cons must hold in the same cycle as ante
`define BQE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> sv/bqe_pkg.sv
// Shared types, constants and helper functions of the billboard quad expander.
// No dependencies.
package bqe_pkg;

   localparam int ATLAS_TILES = 8;
   localparam int ATLAS_ROW   = 6;

   localparam logic [16:0] ONE_Q16    = 17'd65536;
   localparam int          TILE_STEP  = 65536 / ATLAS_TILES;
   localparam logic [16:0] FADE_START = 17'd45875;
   localparam int          FADE_SPAN  = 19661;
   localparam int          FADE_SHIFT = 26;
   localparam int          FADE_RECIP = (1 << FADE_SHIFT) / FADE_SPAN;

   // age divider: 18 quotient bits, 3 per cycle
   localparam int DIV_BITS      = 18;
   localparam int DIV_PER_CYCLE = 3;
   localparam int DIV_CYCLES    = DIV_BITS / DIV_PER_CYCLE;
   localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int VERTS   = 6;
   localparam int VIDX_W  = $clog2(VERTS);

   typedef enum logic [2:0] {
      REG_RIGHT_X = 3'd0,
      REG_RIGHT_Y = 3'd1,
      REG_RIGHT_Z = 3'd2,
      REG_UP_X    = 3'd3,
      REG_UP_Y    = 3'd4,
      REG_UP_Z    = 3'd5,
      REG_LIGHT   = 3'd6
   } csr_idx_type;

   typedef enum logic [1:0] {
      CORNER_BL = 2'd0,
      CORNER_BR = 2'd1,
      CORNER_TR = 2'd2,
      CORNER_TL = 2'd3
   } corner_type;

   typedef struct packed {
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
      logic [16:0]        light_level;
   } cfg_type;

   // particle after the age has been worked out
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [16:0]        age;
      logic [15:0]        size_start;
      logic [15:0]        size_end;
      logic [23:0]        color_rgb;
      logic [7:0]         alpha_start;
      logic [2:0]         tile_index;
      logic               additive_mode;
   } item_type;

   // queue handshake between front and back
   typedef struct packed {
      logic full;
      logic nonempty;
   } qstat_type;

   function automatic logic [16:0] tile_coord(input logic [6:0] n);
      logic [23:0] p;
      p = 24'(n) * 24'(TILE_STEP);
      return (p > 24'(ONE_Q16)) ? ONE_Q16 : p[16:0];
   endfunction

   // triangles bl-br-tr and bl-tr-tl
   function automatic corner_type corner_of(input logic [VIDX_W-1:0] k);
      corner_type c;
      case (k)
         3'd0:    c = CORNER_BL;
         3'd1:    c = CORNER_BR;
         3'd2:    c = CORNER_TR;
         3'd3:    c = CORNER_BL;
         3'd4:    c = CORNER_TR;
         3'd5:    c = CORNER_TL;
         default: c = CORNER_BL;
      endcase
      return c;
   endfunction

endpackage

>>> sv/billboard_quad_expander.sv
// Billboard quad expander: one particle in, six quad vertices out.
// Throughput: one vertex per cycle while fed and popped; a new particle is
//   taken only while the front is idle or its divider hands the last one on.
//   The divider resolves 3 quotient bits a cycle; the emitter holds 4 corners.
// Reset: synchronous, active high; clears all control state and loads the
//   camera axes and light level with their defaults.
`include "assert_macros.svh"

module billboard_quad_expander
   import bqe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // particle input queue side
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [15:0]        req_life_left,
   input  logic [15:0]        req_life_total,
   input  logic [15:0]        req_size_start,
   input  logic [15:0]        req_size_end,
   input  logic [23:0]        req_color_rgb,
   input  logic [7:0]         req_alpha_start,
   input  logic [2:0]         req_tile_index,
   input  logic               req_additive_mode,
   // vertex output queue side
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_vert_x,
   output logic signed [31:0] rsp_vert_y,
   output logic signed [31:0] rsp_vert_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic [7:0]         rsp_alpha,
   output logic               rsp_last_vertex,
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [16:0]        csr_data
);

   cfg_type   cfg_ff, cfg_in;
   qstat_type qstat;
   logic      q_push, q_pop;
   item_type  q_item, head_item;

   // registers are always writable; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            REG_RIGHT_X: cfg_in.right_x     = csr_data[15:0];
            REG_RIGHT_Y: cfg_in.right_y     = csr_data[15:0];
            REG_RIGHT_Z: cfg_in.right_z     = csr_data[15:0];
            REG_UP_X:    cfg_in.up_x        = csr_data[15:0];
            REG_UP_Y:    cfg_in.up_y        = csr_data[15:0];
            REG_UP_Z:    cfg_in.up_z        = csr_data[15:0];
            REG_LIGHT:   cfg_in.light_level = csr_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.right_x     <= 16'sd16384;
         cfg_ff.right_y     <= 16'sd0;
         cfg_ff.right_z     <= 16'sd0;
         cfg_ff.up_x        <= 16'sd0;
         cfg_ff.up_y        <= 16'sd16384;
         cfg_ff.up_z        <= 16'sd0;
         cfg_ff.light_level <= ONE_Q16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: takes a particle and divides out its age
   bqe_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_life_left     (req_life_left),
      .req_life_total    (req_life_total),
      .req_size_start    (req_size_start),
      .req_size_end      (req_size_end),
      .req_color_rgb     (req_color_rgb),
      .req_alpha_start   (req_alpha_start),
      .req_tile_index    (req_tile_index),
      .req_additive_mode (req_additive_mode),
      .qstat             (qstat),
      .q_push            (q_push),
      .q_item            (q_item)
   );

   // two-item decoupling queue
   bqe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   // back: geometry, shading and vertex emission
   bqe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .qstat           (qstat),
      .head_item       (head_item),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_vert_x      (rsp_vert_x),
      .rsp_vert_y      (rsp_vert_y),
      .rsp_vert_z      (rsp_vert_z),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_alpha       (rsp_alpha),
      .rsp_last_vertex (rsp_last_vertex)
   );

   // the divider stays busy after an accept, so an accepted item blocks the next one
   `BQE_ASSERT_NEXT(a_busy_after_accept, req_push && !req_full, req_full, "front not busy after accept")
   // inside a quad the emitter always has the next vertex ready
   `BQE_ASSERT_NEXT(a_quad_no_gap, rsp_pop && !rsp_empty && !rsp_last_vertex, !rsp_empty, "gap inside quad")
   // both sides come out of reset idle
   `BQE_ASSERT_SAME(a_idle_after_reset, $past(reset), !req_full && rsp_empty, "not idle after reset")

endmodule

>>> sv/bqe_front.sv
// Front end: accepts a particle and computes its age with a radix-8 divider.
// Depends on bqe_pkg.
module bqe_front
   import bqe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [15:0]        req_life_left,
   input  logic [15:0]        req_life_total,
   input  logic [15:0]        req_size_start,
   input  logic [15:0]        req_size_end,
   input  logic [23:0]        req_color_rgb,
   input  logic [7:0]         req_alpha_start,
   input  logic [2:0]         req_tile_index,
   input  logic               req_additive_mode,
   input  qstat_type          qstat,
   output logic               q_push,
   output item_type           q_item
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]          rem_ff, rem_in;
   logic [DIV_BITS-1:0]  num_ff, num_in;
   logic [15:0]          quo_ff, quo_in;
   logic [15:0]          total_ff;
   logic                 zero_ff;
   item_type             item_ff;
   logic [15:0]          rem_step, quo_step;
   logic [DIV_BITS-1:0]  num_step;
   logic                 done, accept;

   // three restoring steps per cycle
   always_comb begin
      logic [16:0] r2;
      rem_step = rem_ff;
      num_step = num_ff;
      quo_step = quo_ff;
      for (int j = 0; j < DIV_PER_CYCLE; j++) begin
         r2       = {rem_step, num_step[DIV_BITS-1]};
         num_step = {num_step[DIV_BITS-2:0], 1'b0};
         if (r2 >= {1'b0, total_ff}) begin
            rem_step = 16'(r2 - {1'b0, total_ff});
            quo_step = {quo_step[14:0], 1'b1};
         end else begin
            rem_step = r2[15:0];
            quo_step = {quo_step[14:0], 1'b0};
         end
      end
   end

   assign done     = busy_ff && (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1));
   assign q_push   = done && !qstat.full;
   assign req_full = busy_ff && !q_push;
   assign accept   = req_push && !req_full;

   always_comb begin
      q_item = item_ff;
      if (total_ff == 16'd0) begin
         q_item.age = ONE_Q16;
      end else if (zero_ff) begin
         q_item.age = 17'd0;
      end else begin
         q_item.age = ONE_Q16 - {1'b0, quo_step};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {2'b00, req_life_left[15:2]};
         num_in  = {req_life_left[1:0], 16'd0};
         quo_in  = '0;
      end else if (q_push) begin
         busy_in = 1'b0;
      end else if (busy_ff && !done) begin
         cnt_in = cnt_ff + 1'b1;
         rem_in = rem_step;
         num_in = num_step;
         quo_in = quo_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      if (accept) begin
         total_ff              <= req_life_total;
         zero_ff               <= (req_life_left >= req_life_total);
         item_ff.pos_x         <= req_pos_x;
         item_ff.pos_y         <= req_pos_y;
         item_ff.pos_z         <= req_pos_z;
         item_ff.age           <= '0;
         item_ff.size_start    <= req_size_start;
         item_ff.size_end      <= req_size_end;
         item_ff.color_rgb     <= req_color_rgb;
         item_ff.alpha_start   <= req_alpha_start;
         item_ff.tile_index    <= req_tile_index;
         item_ff.additive_mode <= req_additive_mode;
      end
   end

endmodule

>>> sv/bqe_queue.sv
// Short register queue between the front end and the vertex back end.
// Depends on bqe_pkg.
module bqe_queue
   import bqe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   input  logic      pop,
   output item_type  head_item,
   output qstat_type qstat
);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign qstat.full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.nonempty = (cnt_ff != '0);
   assign do_push        = push && !qstat.full;
   assign do_pop         = pop && qstat.nonempty;
   assign head_item      = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

>>> sv/bqe_back.sv
// Back end: size, offsets, alpha and color pipeline, then the six-vertex emitter.
// Depends on bqe_pkg.
module bqe_back
   import bqe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  qstat_type          qstat,
   input  item_type           head_item,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_vert_x,
   output logic signed [31:0] rsp_vert_y,
   output logic signed [31:0] rsp_vert_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic [7:0]         rsp_alpha,
   output logic               rsp_last_vertex
);

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec_type;

   typedef struct packed {
      vec_type     pos;
      logic [32:0] m0;
      logic [32:0] m1;
      logic [24:0] pa;
      logic [24:0] pr;
      logic [24:0] pg;
      logic [24:0] pb;
      logic [7:0]  a0;
      logic [2:0]  tile;
      logic        fade;
   } s1_type;

   typedef struct packed {
      vec_type     pos;
      logic [15:0] size;
      logic [7:0]  est;
      logic [22:0] pa;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  a0;
      logic [2:0]  tile;
      logic        fade;
   } s2_type;

   typedef struct packed {
      vec_type     pos;
      logic [32:0] orx;
      logic [32:0] ory;
      logic [32:0] orz;
      logic [32:0] oux;
      logic [32:0] ouy;
      logic [32:0] ouz;
      logic [7:0]  est;
      logic [22:0] pa;
      logic [22:0] chk;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  a0;
      logic [2:0]  tile;
      logic        fade;
   } s3_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic               last_vertex;
   } vtx_type;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   logic   v1_ff, v2_ff, v3_ff;
   logic   ld1, ld2, ld3, ld_e;

   vec_type             corner_ff [4];
   vec_type             corner_in [4];
   logic [16:0]         u0_ff, u1_ff, u0_in, u1_in;
   logic [7:0]          r_ff, g_ff, b_ff, a_ff, a_in;
   logic                e_v_ff, e_v_in;
   logic [VIDX_W-1:0]   idx_ff, idx_in;
   logic                e_ready, emit, out_load;
   vtx_type             out_ff, out_in;
   logic                out_v_ff, out_v_in;

   // stage 1: lerp and fade products, lit color products
   always_comb begin
      logic [16:0] inv_t;
      logic [16:0] light;
      inv_t       = ONE_Q16 - head_item.age;
      light       = head_item.additive_mode ? ONE_Q16 : cfg.light_level;
      s1_in.pos.x = head_item.pos_x;
      s1_in.pos.y = head_item.pos_y;
      s1_in.pos.z = head_item.pos_z;
      s1_in.m0    = 33'(head_item.size_start) * 33'(inv_t);
      s1_in.m1    = 33'(head_item.size_end) * 33'(head_item.age);
      s1_in.pa    = 25'(head_item.alpha_start) * 25'(inv_t);
      s1_in.pr    = 25'(head_item.color_rgb[23:16]) * 25'(light);
      s1_in.pg    = 25'(head_item.color_rgb[15:8]) * 25'(light);
      s1_in.pb    = 25'(head_item.color_rgb[7:0]) * 25'(light);
      s1_in.a0    = head_item.alpha_start;
      s1_in.tile  = head_item.tile_index;
      s1_in.fade  = (head_item.age >= FADE_START);
   end

   // stage 2: size, reciprocal estimate of the fade quotient, color saturation
   always_comb begin
      logic [32:0] sum;
      logic [34:0] prod;
      sum        = s1_ff.m0 + s1_ff.m1;
      prod       = 35'(s1_ff.pa[22:0]) * 35'(FADE_RECIP);
      s2_in.pos  = s1_ff.pos;
      s2_in.size = sum[31:16];
      s2_in.est  = prod[FADE_SHIFT+7:FADE_SHIFT];
      s2_in.pa   = s1_ff.pa[22:0];
      s2_in.r    = (s1_ff.pr[24:16] > 9'd255) ? 8'd255 : s1_ff.pr[23:16];
      s2_in.g    = (s1_ff.pg[24:16] > 9'd255) ? 8'd255 : s1_ff.pg[23:16];
      s2_in.b    = (s1_ff.pb[24:16] > 9'd255) ? 8'd255 : s1_ff.pb[23:16];
      s2_in.a0   = s1_ff.a0;
      s2_in.tile = s1_ff.tile;
      s2_in.fade = s1_ff.fade;
   end

   // stage 3: axis times size, estimate times fade span
   always_comb begin
      logic signed [32:0] sz;
      sz         = 33'($signed({1'b0, s2_ff.size}));
      s3_in.pos  = s2_ff.pos;
      s3_in.orx  = 33'($signed(cfg.right_x)) * sz;
      s3_in.ory  = 33'($signed(cfg.right_y)) * sz;
      s3_in.orz  = 33'($signed(cfg.right_z)) * sz;
      s3_in.oux  = 33'($signed(cfg.up_x)) * sz;
      s3_in.ouy  = 33'($signed(cfg.up_y)) * sz;
      s3_in.ouz  = 33'($signed(cfg.up_z)) * sz;
      s3_in.est  = s2_ff.est;
      s3_in.pa   = s2_ff.pa;
      s3_in.chk  = 23'(s2_ff.est) * 23'(FADE_SPAN);
      s3_in.r    = s2_ff.r;
      s3_in.g    = s2_ff.g;
      s3_in.b    = s2_ff.b;
      s3_in.a0   = s2_ff.a0;
      s3_in.tile = s2_ff.tile;
      s3_in.fade = s2_ff.fade;
   end

   // corner positions, final alpha and tile coordinates for the emitter
   always_comb begin
      vec_type     ro, uo;
      logic [22:0] diff;
      logic [8:0]  q;
      ro.x = {{6{s3_ff.orx[32]}}, s3_ff.orx[32:7]};
      ro.y = {{6{s3_ff.ory[32]}}, s3_ff.ory[32:7]};
      ro.z = {{6{s3_ff.orz[32]}}, s3_ff.orz[32:7]};
      uo.x = {{6{s3_ff.oux[32]}}, s3_ff.oux[32:7]};
      uo.y = {{6{s3_ff.ouy[32]}}, s3_ff.ouy[32:7]};
      uo.z = {{6{s3_ff.ouz[32]}}, s3_ff.ouz[32:7]};
      corner_in[CORNER_BL].x = s3_ff.pos.x - ro.x - uo.x;
      corner_in[CORNER_BL].y = s3_ff.pos.y - ro.y - uo.y;
      corner_in[CORNER_BL].z = s3_ff.pos.z - ro.z - uo.z;
      corner_in[CORNER_BR].x = s3_ff.pos.x + ro.x - uo.x;
      corner_in[CORNER_BR].y = s3_ff.pos.y + ro.y - uo.y;
      corner_in[CORNER_BR].z = s3_ff.pos.z + ro.z - uo.z;
      corner_in[CORNER_TR].x = s3_ff.pos.x + ro.x + uo.x;
      corner_in[CORNER_TR].y = s3_ff.pos.y + ro.y + uo.y;
      corner_in[CORNER_TR].z = s3_ff.pos.z + ro.z + uo.z;
      corner_in[CORNER_TL].x = s3_ff.pos.x - ro.x + uo.x;
      corner_in[CORNER_TL].y = s3_ff.pos.y - ro.y + uo.y;
      corner_in[CORNER_TL].z = s3_ff.pos.z - ro.z + uo.z;
      // estimate is low by at most one
      diff = s3_ff.pa - s3_ff.chk;
      q    = (diff >= 23'(FADE_SPAN)) ? 9'(s3_ff.est) + 9'd1 : 9'(s3_ff.est);
      if (!s3_ff.fade || q > 9'(s3_ff.a0)) begin
         a_in = s3_ff.a0;
      end else begin
         a_in = q[7:0];
      end
      u0_in = tile_coord(7'(s3_ff.tile));
      u1_in = tile_coord(7'(s3_ff.tile) + 7'd1);
   end

   // pipeline flow
   assign out_load = !out_v_ff || rsp_pop;
   assign emit     = e_v_ff && out_load;
   assign e_ready  = !e_v_ff || (emit && idx_ff == VIDX_W'(VERTS - 1));
   assign ld_e     = v3_ff && e_ready;
   assign ld3      = !v3_ff || e_ready;
   assign ld2      = !v2_ff || ld3;
   assign ld1      = !v1_ff || ld2;
   assign q_pop    = qstat.nonempty && ld1;

   always_comb begin
      e_v_in = e_v_ff;
      idx_in = idx_ff;
      if (ld_e) begin
         e_v_in = 1'b1;
         idx_in = '0;
      end else if (emit) begin
         if (idx_ff == VIDX_W'(VERTS - 1)) begin
            e_v_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      corner_type c;
      c                  = corner_of(idx_ff);
      out_in.vert_x      = corner_ff[c].x;
      out_in.vert_y      = corner_ff[c].y;
      out_in.vert_z      = corner_ff[c].z;
      out_in.tex_u       = (c == CORNER_BL || c == CORNER_TL) ? u0_ff : u1_ff;
      out_in.tex_v       = (c == CORNER_BL || c == CORNER_BR) ?
                           tile_coord(7'(ATLAS_ROW + 1)) : tile_coord(7'(ATLAS_ROW));
      out_in.red         = r_ff;
      out_in.green       = g_ff;
      out_in.blue        = b_ff;
      out_in.alpha       = a_ff;
      out_in.last_vertex = (idx_ff == VIDX_W'(VERTS - 1));
      if (emit) begin
         out_v_in = 1'b1;
      end else if (rsp_pop) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         e_v_ff   <= 1'b0;
         idx_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= qstat.nonempty;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         e_v_ff   <= e_v_in;
         idx_ff   <= idx_in;
         out_v_ff <= out_v_in;
      end
      if (ld1) s1_ff <= s1_in;
      if (ld2) s2_ff <= s2_in;
      if (ld3) s3_ff <= s3_in;
      if (ld_e) begin
         for (int i = 0; i < 4; i++) begin
            corner_ff[i] <= corner_in[i];
         end
         u0_ff <= u0_in;
         u1_ff <= u1_in;
         r_ff  <= s3_ff.r;
         g_ff  <= s3_ff.g;
         b_ff  <= s3_ff.b;
         a_ff  <= a_in;
      end
      if (emit) out_ff <= out_in;
   end

   assign rsp_empty       = !out_v_ff;
   assign rsp_vert_x      = out_ff.vert_x;
   assign rsp_vert_y      = out_ff.vert_y;
   assign rsp_vert_z      = out_ff.vert_z;
   assign rsp_tex_u       = out_ff.tex_u;
   assign rsp_tex_v       = out_ff.tex_v;
   assign rsp_red         = out_ff.red;
   assign rsp_green       = out_ff.green;
   assign rsp_blue        = out_ff.blue;
   assign rsp_alpha       = out_ff.alpha;
   assign rsp_last_vertex = out_ff.last_vertex;

endmodule

>>> verif/billboard_quad_expander_tb.sv
// Testbench for the billboard quad expander: particles in, six quad vertices out.
// Depends on bqe_pkg and the billboard_quad_expander RTL; a scoreboard class
//   predicts vertices and checks them in order.
`timescale 1ns / 100ps

module billboard_quad_expander_tb
   import bqe_pkg::*;
;

   // one particle as offered on the input side
   typedef struct {
      logic signed [31:0] pos_x, pos_y, pos_z;
      logic [15:0] life_left, life_total, size_start, size_end;
      logic [23:0] color_rgb;
      logic [7:0]  alpha_start;
      logic [2:0]  tile_index;
      logic        additive_mode;
   } particle_type;

   // one vertex as seen on the result side
   typedef struct {
      logic [31:0] vx, vy, vz;
      logic [16:0] u, v;
      logic [7:0]  r, g, b, a;
      logic        last;
   } vertex_type;

   // Vertex predictor plus the queue of vertices still owed by the block.
   class vertex_scoreboard;
      cfg_type    cam;
      vertex_type owed[$];
      int         errors;

      function void reset_regs();
         cam.right_x = 16'sd16384; cam.right_y = 16'sd0; cam.right_z = 16'sd0;
         cam.up_x = 16'sd0; cam.up_y = 16'sd16384; cam.up_z = 16'sd0;
         cam.light_level = 17'd65536;
         errors = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [16:0] d);
         case (idx)
            REG_RIGHT_X: cam.right_x = d[15:0];
            REG_RIGHT_Y: cam.right_y = d[15:0];
            REG_RIGHT_Z: cam.right_z = d[15:0];
            REG_UP_X:    cam.up_x = d[15:0];
            REG_UP_Y:    cam.up_y = d[15:0];
            REG_UP_Z:    cam.up_z = d[15:0];
            REG_LIGHT:   cam.light_level = d;
            default: ;
         endcase
      endfunction

      function logic [7:0] shade(logic [7:0] ch, longint lvl);
         longint s;
         s = (longint'(ch) * lvl) >>> 16;
         return (s > 255) ? 8'd255 : s[7:0];
      endfunction

      // half-edge offset in s15.16: floor(axis * size / 128)
      function longint offs(logic signed [15:0] ax, longint sz);
         longint p;
         p = longint'(ax) * sz;
         return (p >= 0) ? p / 128 : -((-p + 127) / 128);
      endfunction

      function longint uvclip(longint x);
         return (x > 65536) ? 65536 : x;
      endfunction

      // note an accepted particle: queue its six vertices
      function void note_particle(particle_type p);
         longint age, sz, alf, lvl, stp, u0, u1, v0, v1;
         longint ro[3], uo[3], pos[3], cx[4][3], cu[4], cv[4];
         logic [7:0] r, g, b;
         int corner[6] = '{0, 1, 2, 0, 2, 3};
         vertex_type vt;
         if (p.life_total == 16'd0) age = 65536;
         else if (p.life_left >= p.life_total) age = 0;
         else age = 65536 - (longint'(p.life_left) * 65536) / longint'(p.life_total);
         sz = (longint'(p.size_start) * (65536 - age) + longint'(p.size_end) * age) >> 16;
         alf = longint'(p.alpha_start);
         if (age >= 45875) begin
            alf = (longint'(p.alpha_start) * (65536 - age)) / 19661;
            if (alf > longint'(p.alpha_start)) alf = longint'(p.alpha_start);
         end
         lvl = p.additive_mode ? 65536 : longint'(cam.light_level);
         r = shade(p.color_rgb[23:16], lvl);
         g = shade(p.color_rgb[15:8], lvl);
         b = shade(p.color_rgb[7:0], lvl);
         ro[0] = offs(cam.right_x, sz); ro[1] = offs(cam.right_y, sz);
         ro[2] = offs(cam.right_z, sz);
         uo[0] = offs(cam.up_x, sz); uo[1] = offs(cam.up_y, sz); uo[2] = offs(cam.up_z, sz);
         pos[0] = longint'(p.pos_x); pos[1] = longint'(p.pos_y); pos[2] = longint'(p.pos_z);
         for (int i = 0; i < 3; i++) begin
            cx[0][i] = pos[i] - ro[i] - uo[i];
            cx[1][i] = pos[i] + ro[i] - uo[i];
            cx[2][i] = pos[i] + ro[i] + uo[i];
            cx[3][i] = pos[i] - ro[i] + uo[i];
         end
         stp = 65536 / ATLAS_TILES;
         u0 = uvclip(longint'(p.tile_index) * stp);
         u1 = uvclip(longint'(p.tile_index) * stp + stp);
         v0 = uvclip(ATLAS_ROW * stp); v1 = uvclip(ATLAS_ROW * stp + stp);
         cu = '{u0, u1, u1, u0};
         cv = '{v1, v1, v0, v0};
         for (int k = 0; k < 6; k++) begin
            vt.vx = 32'(cx[corner[k]][0]);
            vt.vy = 32'(cx[corner[k]][1]);
            vt.vz = 32'(cx[corner[k]][2]);
            vt.u = 17'(cu[corner[k]]); vt.v = 17'(cv[corner[k]]);
            vt.r = r; vt.g = g; vt.b = b; vt.a = alf[7:0];
            vt.last = (k == 5);
            owed.push_back(vt);
         end
      endfunction

      function void cmp(string nm, longint e, longint a);
         if (e != a) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h got %0h", $time, nm, e, a);
         end
      endfunction

      // check one vertex popped from the block
      function void check_vertex(vertex_type got);
         vertex_type e;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t: unexpected vertex, expected none got x=%0h", $time, got.vx);
            return;
         end
         e = owed.pop_front();
         cmp("vert_x", e.vx, got.vx); cmp("vert_y", e.vy, got.vy);
         cmp("vert_z", e.vz, got.vz); cmp("tex_u", e.u, got.u);
         cmp("tex_v", e.v, got.v); cmp("red", e.r, got.r);
         cmp("green", e.g, got.g); cmp("blue", e.b, got.b);
         cmp("alpha", e.a, got.a); cmp("last_vertex", e.last, got.last);
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_push = 0, req_full;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic [15:0] req_life_left = 0, req_life_total = 0, req_size_start = 0, req_size_end = 0;
   logic [23:0] req_color_rgb = 0;
   logic [7:0]  req_alpha_start = 0;
   logic [2:0]  req_tile_index = 0;
   logic        req_additive_mode = 0;
   logic rsp_empty, rsp_pop = 0;
   logic signed [31:0] rsp_vert_x, rsp_vert_y, rsp_vert_z;
   logic [16:0] rsp_tex_u, rsp_tex_v;
   logic [7:0]  rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic        rsp_last_vertex;
   logic csr_valid = 0, csr_ready;
   logic [2:0]  csr_index = 0;
   logic [16:0] csr_data = 0;

   vertex_scoreboard quad_sb;
   int  cycle_count = 0;
   bit  hold_off = 0;     // long receiver stall requested by the stimulus
   bit  no_gaps = 0;      // stretch with no idling on either side

   localparam int CYCLE_LIMIT = 400000;

   billboard_quad_expander uut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("billboard_quad_expander_tb NOT OK");
         $finish;
      end
   end

   // Receiver: checks at every accepting edge, then idles a random gap
   // before it asks for the next vertex; the long hold-off overrides it.
   initial begin
      int gap;
      gap = 0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            quad_sb.check_vertex('{rsp_vert_x, rsp_vert_y, rsp_vert_z, rsp_tex_u,
                                   rsp_tex_v, rsp_red, rsp_green, rsp_blue,
                                   rsp_alpha, rsp_last_vertex});
            gap = no_gaps ? 0 : $urandom_range(0, 9);
         end
         if (reset || hold_off) begin
            rsp_pop <= 0;
         end else if (gap > 0) begin
            rsp_pop <= 0;
            gap--;
         end else begin
            rsp_pop <= 1;
         end
      end
   end

   // Offer one particle after a random gap and wait until it is taken.
   // push stays high after acceptance so the next item can follow at once.
   task automatic push_particle(particle_type p);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_pos_x <= p.pos_x; req_pos_y <= p.pos_y; req_pos_z <= p.pos_z;
      req_life_left <= p.life_left; req_life_total <= p.life_total;
      req_size_start <= p.size_start; req_size_end <= p.size_end;
      req_color_rgb <= p.color_rgb; req_alpha_start <= p.alpha_start;
      req_tile_index <= p.tile_index; req_additive_mode <= p.additive_mode;
      req_push <= 1;
      do @(posedge clock); while (req_full);
      quad_sb.note_particle(p);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [16:0] d);
      csr_index <= idx; csr_data <= d; csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      quad_sb.write_reg(idx, d);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // Stop offering, let every owed vertex arrive, then let the block idle.
   task automatic drain();
      req_push <= 0;
      while (quad_sb.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic particle_type rand_particle();
      particle_type p;
      p.pos_x = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
      // mostly short sizes and sensible lives, sometimes full range
      if ($urandom_range(0, 3) == 0) begin
         p.life_total = 16'($urandom); p.life_left = 16'($urandom);
         p.size_start = 16'($urandom); p.size_end = 16'($urandom);
      end else begin
         p.life_total = 16'($urandom_range(0, 2000));
         p.life_left = 16'($urandom_range(0, p.life_total));
         p.size_start = 16'($urandom_range(0, 1024));
         p.size_end = 16'($urandom_range(0, 1024));
      end
      p.color_rgb = 24'($urandom); p.alpha_start = 8'($urandom);
      p.tile_index = 3'($urandom); p.additive_mode = 1'($urandom);
      return p;
   endfunction

   function automatic particle_type mk(logic [15:0] ll, logic [15:0] lt, logic [15:0] s0,
                                      logic [15:0] s1, logic [2:0] tile, logic add);
      particle_type p;
      p = rand_particle();
      p.life_left = ll; p.life_total = lt; p.size_start = s0; p.size_end = s1;
      p.tile_index = tile; p.additive_mode = add;
      return p;
   endfunction

   task automatic random_config(bit extreme);
      for (int i = 0; i < 6; i++)
         write_csr(csr_idx_type'(i),
                   extreme ? ($urandom_range(0, 1) ? 17'h08000 : 17'h07fff) : 17'($urandom));
      write_csr(REG_LIGHT, extreme ? 17'h1ffff : 17'($urandom_range(16384, 65536)));
   endtask

   initial begin
      particle_type p;
      quad_sb = new();
      quad_sb.reset_regs();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, age corners, fade region, tiles, light modes
      push_particle(mk(16'd0, 16'd0, 16'hffff, 16'h0000, 3'd0, 1'b0));  // zero total life
      push_particle(mk(16'hffff, 16'h0001, 16'hffff, 16'hffff, 3'd7, 1'b1)); // left past total
      push_particle(mk(16'd100, 16'd100, 16'd256, 16'd512, 3'd1, 1'b0));
      push_particle(mk(16'd30, 16'd100, 16'd256, 16'd512, 3'd2, 1'b0));  // fade starts
      push_particle(mk(16'd29, 16'd100, 16'd256, 16'd512, 3'd3, 1'b1));
      push_particle(mk(16'd1, 16'hffff, 16'h0, 16'hffff, 3'd4, 1'b0));   // near death
      p = mk(16'd0, 16'd10, 16'hffff, 16'hffff, 3'd5, 1'b0);
      p.pos_x = 32'h7fffffff; p.pos_y = 32'h80000000; p.pos_z = 32'hffffffff;
      p.color_rgb = 24'hffffff; p.alpha_start = 8'hff;
      push_particle(p);                                                  // wraparound
      p.pos_x = 32'h80000000; p.pos_y = 32'h7fffffff; p.color_rgb = 24'd0;
      p.alpha_start = 8'd0;
      push_particle(p);
      drain();
      // light above one, then below range, with extreme axes
      random_config(1'b1);
      for (int i = 0; i < 6; i++) push_particle(mk(16'd5, 16'd9, 16'hffff, 16'h1, 3'(i), 1'b0));
      drain();
      write_csr(REG_LIGHT, 17'd100);
      write_csr(csr_idx_type'(3'd7), 17'h1ffff);                        // unknown index, ignored
      for (int i = 0; i < 4; i++) push_particle(mk(16'd2, 16'd9, 16'h100, 16'h80, 3'd6, i[0]));
      drain();

      // random phases with changing settings
      for (int ph = 0; ph < 7; ph++) begin
         random_config(ph == 3);
         if (ph == 2) no_gaps = 1;
         if (ph == 4) fork
            begin
               hold_off = 1;
               repeat (300) @(posedge clock);
               hold_off = 0;
            end
         join_none
         for (int n = 0; n < 48; n++) begin
            push_particle(rand_particle());
            if (n == 20 && ph == 5) drain();
         end
         drain();
         no_gaps = 0;
      end

      if (quad_sb.errors == 0 && quad_sb.owed.size() == 0)
         $display("billboard_quad_expander_tb OK");
      else
         $display("billboard_quad_expander_tb NOT OK");
      $finish;
   end
endmodule
